[rtl/core/lph_pkg.sv]
package lph_pkg;

    localparam int OP_W              = 2;
    localparam int IN_W              = 32;
    localparam int SLOT_W            = 10;
    localparam int COUNT_W           = 11;
    localparam int S_TDATA_W         = 96;
    localparam int M_TDATA_W         = 56;
    localparam int M_TUSER_W         = 3;

    localparam int TABLE_DEPTH_DEF   = 1024;
    localparam int KEY_BITS_DEF      = 32;
    localparam int VALUE_BITS_DEF    = 32;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [COUNT_W-1:0] LOAD_LIMIT_RESET = 11'd512;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_SET    = 2'd2;

    typedef enum logic [M_TUSER_W-1:0] {
        ST_HIT     = 3'd0,
        ST_MISS    = 3'd1,
        ST_NEW     = 3'd2,
        ST_PRESENT = 3'd3,
        ST_FULL    = 3'd4,
        ST_ZERO    = 3'd5
    } status_t;

endpackage

[rtl/core/lph_queue.sv]
module lph_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] ent_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = cnt_reg != CNT_W'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data  = ent_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            ent_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[rtl/core/lph_front.sv]
module lph_front #(
    parameter int TABLE_DEPTH = lph_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = lph_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = lph_pkg::VALUE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         hold,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lph_pkg::OP_W-1:0]     s_op,
    input  logic [lph_pkg::IN_W-1:0]     s_key,
    input  logic [lph_pkg::IN_W-1:0]     s_hash,
    input  logic [lph_pkg::IN_W-1:0]     s_value,
    output logic                         q_valid,
    input  logic                         q_ready,
    output logic [lph_pkg::OP_W + KEY_BITS + VALUE_BITS + lph_pkg::IN_W
                  + $clog2(TABLE_DEPTH):0] q_data
);

    localparam int IDX     = $clog2(TABLE_DEPTH);
    localparam int RECIP_W = lph_pkg::IN_W + 1;
    localparam int SCALE   = lph_pkg::IN_W + IDX;
    localparam int PROD_W  = SCALE + IDX;
    // 2^SCALE / TABLE_DEPTH rounded up gives the exact quotient for every hash
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SCALE) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));
    localparam logic [IDX-1:0] DEPTH_LOW = IDX'(TABLE_DEPTH);

    typedef struct packed {
        logic [lph_pkg::OP_W-1:0] op;
        logic [KEY_BITS-1:0]      key;
        logic [VALUE_BITS-1:0]    value;
        logic [lph_pkg::IN_W-1:0] hash;
        logic [IDX-1:0]           start;
        logic                     zero;
    } entry_t;

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_REM, F_PUSH} state_t;

    state_t              state_reg, state_next;
    entry_t              entry_reg, entry_next;
    logic [IDX-1:0]      quot_reg, quot_next;
    logic [PROD_W-1:0]   prod;

    assign q_data  = entry_reg;
    assign q_valid = state_reg == F_PUSH;
    assign s_ready = !hold && ((state_reg == F_IDLE) || (state_reg == F_PUSH && q_ready));

    // hash times reciprocal, only the low quotient bits are kept
    assign prod = PROD_W'(entry_reg.hash) * PROD_W'(RECIP);

    always_comb begin
        state_next = state_reg;
        entry_next = entry_reg;
        quot_next  = quot_reg;

        unique case (state_reg)
            F_IDLE: begin
            end
            F_MUL: begin
                quot_next  = prod[SCALE +: IDX];
                state_next = F_REM;
            end
            F_REM: begin
                // remainder fits in the slot index, so low bits suffice
                entry_next.start = entry_reg.hash[IDX-1:0] - quot_reg * DEPTH_LOW;
                state_next       = F_PUSH;
            end
            F_PUSH: begin
                if (q_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase

        if (s_valid && s_ready) begin
            entry_next.op    = s_op;
            entry_next.key   = KEY_BITS'(s_key);
            entry_next.value = VALUE_BITS'(s_value);
            entry_next.hash  = s_hash;
            entry_next.start = '0;
            entry_next.zero  = s_hash == '0;
            state_next       = F_MUL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        entry_reg <= entry_next;
        quot_reg  <= quot_next;
    end

endmodule

[rtl/core/lph_back.sv]
module lph_back #(
    parameter int TABLE_DEPTH = lph_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = lph_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = lph_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [lph_pkg::OP_W + KEY_BITS + VALUE_BITS + lph_pkg::IN_W
                  + $clog2(TABLE_DEPTH):0] q_data,
    input  logic [lph_pkg::COUNT_W-1:0]   load_limit,
    output logic                          clearing,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lph_pkg::status_t              m_status,
    output logic [lph_pkg::SLOT_W-1:0]    m_slot,
    output logic [lph_pkg::IN_W-1:0]      m_found,
    output logic [lph_pkg::COUNT_W-1:0]   m_count
);

    localparam int IDX     = $clog2(TABLE_DEPTH);
    localparam int PROBE_W = $clog2(TABLE_DEPTH + 1);

    typedef struct packed {
        logic [lph_pkg::OP_W-1:0] op;
        logic [KEY_BITS-1:0]      key;
        logic [VALUE_BITS-1:0]    value;
        logic [lph_pkg::IN_W-1:0] hash;
        logic [IDX-1:0]           start;
        logic                     zero;
    } entry_t;

    typedef struct packed {
        logic [lph_pkg::IN_W-1:0] hash;
        logic [KEY_BITS-1:0]      key;
        logic [VALUE_BITS-1:0]    value;
    } row_t;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_PROBE} state_t;

    row_t mem [TABLE_DEPTH];
    row_t           rd_row_reg;
    logic [IDX-1:0] rd_addr;
    logic           wr_en;
    logic [IDX-1:0] wr_addr;
    row_t           wr_row;

    state_t                        state_reg, state_next;
    entry_t                        q_entry;
    entry_t                        item_reg, item_next;
    logic [IDX-1:0]                pos_reg, pos_next, pos_inc;
    logic [PROBE_W-1:0]            probes_reg, probes_next;
    logic [lph_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic                          m_valid_reg, m_valid_next;
    lph_pkg::status_t              status_reg, status_next;
    logic [lph_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [lph_pkg::IN_W-1:0]      found_reg, found_next;
    logic [lph_pkg::COUNT_W-1:0]   cnt_out_reg, cnt_out_next;
    logic                          out_free, is_write, empty, hit, last;

    assign q_entry  = q_data;
    assign clearing = state_reg == S_CLEAR;
    assign m_valid  = m_valid_reg;
    assign m_status = status_reg;
    assign m_slot   = slot_reg;
    assign m_found  = found_reg;
    assign m_count  = cnt_out_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign pos_inc  = (pos_reg == IDX'(TABLE_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
    assign is_write = (item_reg.op == lph_pkg::OP_INSERT) || (item_reg.op == lph_pkg::OP_SET);
    assign empty    = rd_row_reg.hash == '0;
    assign hit      = (rd_row_reg.hash == item_reg.hash) && (rd_row_reg.key == item_reg.key);
    assign last     = probes_reg == PROBE_W'(TABLE_DEPTH);

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        pos_next     = pos_reg;
        probes_next  = probes_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        slot_next    = slot_reg;
        found_next   = found_reg;
        cnt_out_next = cnt_out_reg;
        q_ready      = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_row       = '0;
        rd_addr      = pos_inc;

        unique case (state_reg)
            S_CLEAR: begin
                wr_en    = 1'b1;
                pos_next = pos_inc;
                if (pos_reg == IDX'(TABLE_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                rd_addr = q_entry.start;
                if (q_valid && out_free) begin
                    q_ready     = 1'b1;
                    item_next   = q_entry;
                    pos_next    = q_entry.start;
                    probes_next = PROBE_W'(1);
                    if (q_entry.zero) begin
                        m_valid_next = 1'b1;
                        status_next  = lph_pkg::ST_ZERO;
                        slot_next    = '0;
                        found_next   = '0;
                        cnt_out_next = count_reg;
                    end else begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (empty || hit || last) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    slot_next    = '0;
                    found_next   = '0;
                    cnt_out_next = count_reg;
                    if (is_write) begin
                        if (hit) begin
                            status_next = lph_pkg::ST_PRESENT;
                            slot_next   = lph_pkg::SLOT_W'(pos_reg);
                            if (item_reg.op == lph_pkg::OP_SET) begin
                                wr_en        = 1'b1;
                                wr_row       = rd_row_reg;
                                wr_row.value = item_reg.value;
                            end
                        end else if (!empty || count_reg >= load_limit) begin
                            status_next = lph_pkg::ST_FULL;
                        end else begin
                            status_next  = lph_pkg::ST_NEW;
                            slot_next    = lph_pkg::SLOT_W'(pos_reg);
                            wr_en        = 1'b1;
                            wr_row.hash  = item_reg.hash;
                            wr_row.key   = item_reg.key;
                            wr_row.value = (item_reg.op == lph_pkg::OP_SET) ? item_reg.value : '0;
                            count_next   = count_reg + 1'b1;
                            cnt_out_next = count_reg + 1'b1;
                        end
                    end else if (hit) begin
                        status_next = lph_pkg::ST_HIT;
                        slot_next   = lph_pkg::SLOT_W'(pos_reg);
                        found_next  = lph_pkg::IN_W'(rd_row_reg.value);
                    end else begin
                        status_next = lph_pkg::ST_MISS;
                        if (empty) begin
                            slot_next = lph_pkg::SLOT_W'(pos_reg);
                        end
                    end
                end else begin
                    pos_next    = pos_inc;
                    probes_next = probes_reg + 1'b1;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        rd_row_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            pos_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg    <= item_next;
        probes_reg  <= probes_next;
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        found_reg   <= found_next;
        cnt_out_reg <= cnt_out_next;
    end

endmodule

[rtl/core/linear_probe_hash_table.sv]
// flow: the front computes the start slot by reciprocal hash modulo (multiply, then
// remainder) and hands the item to a queue; the back then walks the probe sequence
// (one slot read per cycle) and registers the result; a zero hash skips the probe walk
// the front takes a new item while earlier items wait in the queue or are being probed
// reset: aresetn synchronous active low; a clearing pass then writes every slot empty
// with s_tready low; load_limit resets to 512
module linear_probe_hash_table #(
    parameter int TABLE_DEPTH = lph_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = lph_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = lph_pkg::VALUE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lph_pkg::COUNT_W-1:0]     cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lph_pkg::S_TDATA_W-1:0]   s_tdata,  // key, key_hash, value
    input  logic [lph_pkg::OP_W-1:0]        s_tuser,  // operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lph_pkg::M_TDATA_W-1:0]   m_tdata,  // slot_index, found_value, entry_count
    output logic [lph_pkg::M_TUSER_W-1:0]   m_tuser   // status
);

    localparam int ENTRY_W = lph_pkg::OP_W + KEY_BITS + VALUE_BITS + lph_pkg::IN_W
                             + $clog2(TABLE_DEPTH) + 1;

    logic [lph_pkg::COUNT_W-1:0] load_limit_reg;
    logic                        clearing;
    logic                        fq_valid, fq_ready, bq_valid, bq_ready;
    logic [ENTRY_W-1:0]          fq_data, bq_data;
    lph_pkg::status_t            m_status;
    logic [lph_pkg::SLOT_W-1:0]  m_slot;
    logic [lph_pkg::IN_W-1:0]    m_found;
    logic [lph_pkg::COUNT_W-1:0] m_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_limit_reg <= lph_pkg::LOAD_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            load_limit_reg <= cfg_wr_data;
        end
    end

    lph_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .hold    (clearing),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_op    (s_tuser),
        .s_key   (s_tdata[lph_pkg::IN_W-1:0]),
        .s_hash  (s_tdata[2*lph_pkg::IN_W-1:lph_pkg::IN_W]),
        .s_value (s_tdata[3*lph_pkg::IN_W-1:2*lph_pkg::IN_W]),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    lph_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (lph_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    lph_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (bq_valid),
        .q_ready    (bq_ready),
        .q_data     (bq_data),
        .load_limit (load_limit_reg),
        .clearing   (clearing),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_status   (m_status),
        .m_slot     (m_slot),
        .m_found    (m_found),
        .m_count    (m_count)
    );

    assign m_tuser = m_status;
    assign m_tdata = lph_pkg::M_TDATA_W'({m_count, m_found, m_slot});

endmodule
